@@ hdl/miah_pkg.sv @@
// ----------------------------------------------------------------------------
// miah_pkg
// Shared types, operation codes and widths for the integer unit with HI/LO.
// ----------------------------------------------------------------------------
package miah_pkg;

    localparam int WORD_W  = 32;
    localparam int IMM_W   = 16;
    localparam int SHAMT_W = 5;
    localparam int OP_W    = 5;
    localparam int CNT_W   = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] WORD_ONES = {WORD_W{1'b1}};
    localparam logic [WORD_W-1:0] WORD_ONE  = WORD_W'(1);

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD   = 5'd0;
    localparam logic [OP_W-1:0] OP_ADDU  = 5'd1;
    localparam logic [OP_W-1:0] OP_ADDI  = 5'd2;
    localparam logic [OP_W-1:0] OP_ADDIU = 5'd3;
    localparam logic [OP_W-1:0] OP_SUBU  = 5'd4;
    localparam logic [OP_W-1:0] OP_OR    = 5'd5;
    localparam logic [OP_W-1:0] OP_ORI   = 5'd6;
    localparam logic [OP_W-1:0] OP_XOR   = 5'd7;
    localparam logic [OP_W-1:0] OP_XORI  = 5'd8;
    localparam logic [OP_W-1:0] OP_NOR   = 5'd9;
    localparam logic [OP_W-1:0] OP_AND   = 5'd10;
    localparam logic [OP_W-1:0] OP_ANDI  = 5'd11;
    localparam logic [OP_W-1:0] OP_SLL   = 5'd12;
    localparam logic [OP_W-1:0] OP_SLLV  = 5'd13;
    localparam logic [OP_W-1:0] OP_SRL   = 5'd14;
    localparam logic [OP_W-1:0] OP_SRLV  = 5'd15;
    localparam logic [OP_W-1:0] OP_SRA   = 5'd16;
    localparam logic [OP_W-1:0] OP_SRAV  = 5'd17;
    localparam logic [OP_W-1:0] OP_SLTI  = 5'd18;
    localparam logic [OP_W-1:0] OP_SLTIU = 5'd19;
    localparam logic [OP_W-1:0] OP_SLT   = 5'd20;
    localparam logic [OP_W-1:0] OP_SLTU  = 5'd21;
    localparam logic [OP_W-1:0] OP_DIV   = 5'd22;
    localparam logic [OP_W-1:0] OP_DIVU  = 5'd23;
    localparam logic [OP_W-1:0] OP_MULT  = 5'd24;
    localparam logic [OP_W-1:0] OP_MULTU = 5'd25;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [WORD_W-1:0]  rs_value;
        logic [WORD_W-1:0]  rt_value;
        logic [IMM_W-1:0]   immediate;
        logic [SHAMT_W-1:0] shamt;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic              writes_register;
        logic              overflow;
        logic [WORD_W-1:0] hi_value;
        logic [WORD_W-1:0] lo_value;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic load_alu;
        logic start;
        logic mul_step;
        logic div_step;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
    } t_stat;

endpackage

@@ hdl/miah_ctrl.sv @@
// ----------------------------------------------------------------------------
// miah_ctrl
// Sequencer for the integer unit: handshakes, multiply and divide steps.
// ----------------------------------------------------------------------------
module miah_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  miah_pkg::t_stat i_stat,
    output miah_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_MUL      = 5'b00010,
        S_MUL_DONE = 5'b00100,
        S_DIV      = 5'b01000,
        S_DIV_DONE = 5'b10000
    } t_state;

    t_state                      r_state, n_state;
    logic [miah_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                        r_out_valid, n_out_valid;
    logic                        out_free;
    logic                        in_xfer;

    // output register can take a new result
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_stat.is_div) begin
                        o_cmd.start = 1'b1;
                        n_cnt       = '0;
                        n_state     = S_DIV;
                    end else if (i_stat.is_mul) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_MUL;
                    end else begin
                        o_cmd.load_alu = 1'b1;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_state        = S_MUL_DONE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == miah_pkg::CNT_W'(miah_pkg::WORD_W - 1)) begin
                    n_state = S_DIV_DONE;
                end
            end
            S_MUL_DONE, S_DIV_DONE: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid: set on a new result, cleared on transfer
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (o_cmd.load_alu || o_cmd.finish) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ hdl/miah_dp.sv @@
// ----------------------------------------------------------------------------
// miah_dp
// Datapath: combinational ALU, registered multiplier with sign correction,
// radix-2 restoring divider, HI/LO and the output register.
// ----------------------------------------------------------------------------
module miah_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  miah_pkg::t_in   i_in,
    input  miah_pkg::t_cmd  i_cmd,
    output miah_pkg::t_stat o_stat,
    output miah_pkg::t_out  o_out
);

    localparam int W = miah_pkg::WORD_W;

    logic [W-1:0]   rs, rt, imm_s, imm_z, sum_rt, sum_imm;
    logic [4:0]     vsh;
    logic [W-1:0]   alu_res;
    logic           alu_wr, alu_ovf;

    logic [miah_pkg::OP_W-1:0] r_op;
    logic [W-1:0]   r_a, r_b;
    logic [2*W-1:0] r_prod;
    logic [W-1:0]   r_corr;
    logic [W-1:0]   r_quo, r_rem, r_dvs;
    logic           r_neg_q, r_neg_r;
    logic [W-1:0]   r_hi, r_lo;
    miah_pkg::t_out r_out;

    logic           div_signed, neg_a, neg_b;
    logic [W:0]     shifted, trial;
    logic [W-1:0]   fin_hi, fin_lo;

    assign rs      = i_in.rs_value;
    assign rt      = i_in.rt_value;
    assign imm_z   = W'(i_in.immediate);
    assign imm_s   = {{(W - miah_pkg::IMM_W){i_in.immediate[miah_pkg::IMM_W-1]}},
                      i_in.immediate};
    assign vsh     = rs[4:0];
    assign sum_rt  = rs + rt;
    assign sum_imm = rs + imm_s;

    // operation class for the sequencer
    assign o_stat.is_div = (i_in.operation == miah_pkg::OP_DIV) ||
                           (i_in.operation == miah_pkg::OP_DIVU);
    assign o_stat.is_mul = (i_in.operation == miah_pkg::OP_MULT) ||
                           (i_in.operation == miah_pkg::OP_MULTU);

    // combinational operations
    always_comb begin
        alu_res = '0;
        alu_wr  = 1'b1;
        alu_ovf = 1'b0;
        case (i_in.operation)
            miah_pkg::OP_ADD: begin
                alu_res = sum_rt;
                alu_ovf = (rs[W-1] ^ sum_rt[W-1]) & (rt[W-1] ^ sum_rt[W-1]);
            end
            miah_pkg::OP_ADDU:  alu_res = sum_rt;
            miah_pkg::OP_ADDI: begin
                alu_res = sum_imm;
                alu_ovf = (rs[W-1] ^ sum_imm[W-1]) & (imm_s[W-1] ^ sum_imm[W-1]);
            end
            miah_pkg::OP_ADDIU: alu_res = sum_imm;
            miah_pkg::OP_SUBU:  alu_res = rs - rt;
            miah_pkg::OP_OR:    alu_res = rs | rt;
            miah_pkg::OP_ORI:   alu_res = rs | imm_z;
            miah_pkg::OP_XOR:   alu_res = rs ^ rt;
            miah_pkg::OP_XORI:  alu_res = rs ^ imm_z;
            miah_pkg::OP_NOR:   alu_res = ~(rs | rt);
            miah_pkg::OP_AND:   alu_res = rs & rt;
            miah_pkg::OP_ANDI:  alu_res = rs & imm_z;
            miah_pkg::OP_SLL:   alu_res = rt << i_in.shamt;
            miah_pkg::OP_SLLV:  alu_res = rt << vsh;
            miah_pkg::OP_SRL:   alu_res = rt >> i_in.shamt;
            miah_pkg::OP_SRLV:  alu_res = rt >> vsh;
            miah_pkg::OP_SRA:   alu_res = W'($signed(rt) >>> i_in.shamt);
            miah_pkg::OP_SRAV:  alu_res = W'($signed(rt) >>> vsh);
            miah_pkg::OP_SLTI:  alu_res = W'($signed(rs) < $signed(imm_s));
            miah_pkg::OP_SLTIU: alu_res = W'(rs < imm_s);
            miah_pkg::OP_SLT:   alu_res = W'($signed(rs) < $signed(rt));
            miah_pkg::OP_SLTU:  alu_res = W'(rs < rt);
            default:            alu_wr  = 1'b0;
        endcase
        if (alu_ovf) begin
            alu_wr = 1'b0;
        end
        if (!alu_wr) begin
            alu_res = '0;
        end
    end

    // divider operand magnitudes
    assign div_signed = (i_in.operation == miah_pkg::OP_DIV);
    assign neg_a      = div_signed && rs[W-1];
    assign neg_b      = div_signed && rt[W-1];

    // operand capture and multi-cycle work
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op    <= i_in.operation;
            r_a     <= rs;
            r_b     <= rt;
            r_quo   <= neg_a ? (W'(0) - rs) : rs;
            r_dvs   <= neg_b ? (W'(0) - rt) : rt;
            r_rem   <= '0;
            r_neg_q <= neg_a ^ neg_b;
            r_neg_r <= neg_a;
        end
        if (i_cmd.mul_step) begin
            r_prod <= (2*W)'(r_a) * (2*W)'(r_b);
            if (r_op == miah_pkg::OP_MULT) begin
                r_corr <= (r_a[W-1] ? r_b : '0) + (r_b[W-1] ? r_a : '0);
            end else begin
                r_corr <= '0;
            end
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[W-2:0], !trial[W]};
            r_rem <= trial[W] ? shifted[W-1:0] : trial[W-1:0];
        end
    end

    // one restoring step
    assign shifted = {r_rem, r_quo[W-1]};
    assign trial   = shifted - {1'b0, r_dvs};

    // final HI/LO for multiply or divide
    always_comb begin
        fin_hi = r_prod[2*W-1:W] - r_corr;
        fin_lo = r_prod[W-1:0];
        if ((r_op == miah_pkg::OP_DIV) || (r_op == miah_pkg::OP_DIVU)) begin
            if (r_b == '0) begin
                fin_hi = r_a;
                fin_lo = ((r_op == miah_pkg::OP_DIV) && r_a[W-1])
                       ? miah_pkg::WORD_ONE : miah_pkg::WORD_ONES;
            end else begin
                fin_hi = r_neg_r ? (W'(0) - r_rem) : r_rem;
                fin_lo = r_neg_q ? (W'(0) - r_quo) : r_quo;
            end
        end
    end

    // HI/LO state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi <= '0;
            r_lo <= '0;
        end else if (i_cmd.finish) begin
            r_hi <= fin_hi;
            r_lo <= fin_lo;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_alu) begin
            r_out.result          <= alu_res;
            r_out.writes_register <= alu_wr;
            r_out.overflow        <= alu_ovf;
            r_out.hi_value        <= r_hi;
            r_out.lo_value        <= r_lo;
        end else if (i_cmd.finish) begin
            r_out.result          <= '0;
            r_out.writes_register <= 1'b0;
            r_out.overflow        <= 1'b0;
            r_out.hi_value        <= fin_hi;
            r_out.lo_value        <= fin_lo;
        end
    end

    assign o_out = r_out;

endmodule

@@ hdl/mips_integer_alu_hilo_unit.sv @@
// ----------------------------------------------------------------------------
// mips_integer_alu_hilo_unit
// 32-bit MIPS integer unit with HI and LO registers.
// ----------------------------------------------------------------------------
// One operation per transfer, one result per operation. Logic, add, shift
// and compare operations finish in the acceptance cycle, so a stream of them
// runs at one per clock while results are taken. mult/multu: operand capture,
// a registered 32x32 multiplier, then a signed correction of the upper word.
// div/divu: operand capture, 32 iterations of a radix-2 restoring divider,
// then the sign fix-up. Overflowing add/addi reports the flag and no write;
// HI and LO are output with every result and reset to zero.
module mips_integer_alu_hilo_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  miah_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output miah_pkg::t_out o_out
);

    miah_pkg::t_cmd  cmd;
    miah_pkg::t_stat stat;

    // sequencer
    miah_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath
    miah_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_out   (o_out)
    );

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 32-bit integer unit with HI and LO.
// ----------------------------------------------------------------------------
// A shadow copy of HI/LO and a cycle-free predictor compute the expected
// result of every operation as it is accepted. A monitor compares every
// result transfer, field by field, against the oldest prediction. Stimulus
// is a directed pass over every operation and corner case, then random
// operations under several idle/stall mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // opcode range the block leaves unused
    localparam logic [miah_pkg::OP_W-1:0] OP_UNUSED_LO = 5'd26;
    localparam logic [miah_pkg::OP_W-1:0] OP_UNUSED_HI = 5'd31;

    localparam logic [miah_pkg::WORD_W-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [miah_pkg::WORD_W-1:0] MOST_POS = 32'h7FFF_FFFF;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_OFF_CYCLES = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    miah_pkg::t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    miah_pkg::t_out o_out;

    // shadow of the block's HI/LO registers
    logic [miah_pkg::WORD_W-1:0] hi_shadow = '0;
    logic [miah_pkg::WORD_W-1:0] lo_shadow = '0;

    miah_pkg::t_out pending_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int ops_accepted = 0;
    int results_checked = 0;
    int fail_count = 0;

    mips_integer_alu_hilo_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // expected result of one operation, advancing the HI/LO shadow
    function automatic miah_pkg::t_out alu_predict(input miah_pkg::t_in op_in);
        miah_pkg::t_out              res_out;
        logic [miah_pkg::WORD_W-1:0] rs;
        logic [miah_pkg::WORD_W-1:0] rt;
        logic [miah_pkg::WORD_W-1:0] imm_z;
        logic [miah_pkg::WORD_W-1:0] imm_s;
        logic [miah_pkg::WORD_W-1:0] sum;
        logic [miah_pkg::WORD_W-1:0] ua;
        logic [miah_pkg::WORD_W-1:0] ub;
        logic [miah_pkg::WORD_W-1:0] quo;
        logic [miah_pkg::WORD_W-1:0] rem;
        logic [63:0]                 prod;
        logic [4:0]                  vsh;
        logic                        wr;
        logic                        ovf;
        rs    = op_in.rs_value;
        rt    = op_in.rt_value;
        imm_z = {16'h0000, op_in.immediate};
        imm_s = {{16{op_in.immediate[15]}}, op_in.immediate};
        vsh   = rs[4:0];
        sum   = '0;
        wr    = 1'b1;
        ovf   = 1'b0;
        case (op_in.operation)
            miah_pkg::OP_ADD: begin
                sum = rs + rt;
                ovf = (rs[31] ^ sum[31]) & (rt[31] ^ sum[31]);
            end
            miah_pkg::OP_ADDU:  sum = rs + rt;
            miah_pkg::OP_ADDI: begin
                sum = rs + imm_s;
                ovf = (rs[31] ^ sum[31]) & (imm_s[31] ^ sum[31]);
            end
            miah_pkg::OP_ADDIU: sum = rs + imm_s;
            miah_pkg::OP_SUBU:  sum = rs - rt;
            miah_pkg::OP_OR:    sum = rs | rt;
            miah_pkg::OP_ORI:   sum = rs | imm_z;
            miah_pkg::OP_XOR:   sum = rs ^ rt;
            miah_pkg::OP_XORI:  sum = rs ^ imm_z;
            miah_pkg::OP_NOR:   sum = ~(rs | rt);
            miah_pkg::OP_AND:   sum = rs & rt;
            miah_pkg::OP_ANDI:  sum = rs & imm_z;
            miah_pkg::OP_SLL:   sum = rt << op_in.shamt;
            miah_pkg::OP_SLLV:  sum = rt << vsh;
            miah_pkg::OP_SRL:   sum = rt >> op_in.shamt;
            miah_pkg::OP_SRLV:  sum = rt >> vsh;
            miah_pkg::OP_SRA:   sum = $signed(rt) >>> op_in.shamt;
            miah_pkg::OP_SRAV:  sum = $signed(rt) >>> vsh;
            miah_pkg::OP_SLTI:
                sum = ($signed(rs) < $signed(imm_s)) ? miah_pkg::WORD_ONE : '0;
            miah_pkg::OP_SLTIU: sum = (rs < imm_s) ? miah_pkg::WORD_ONE : '0;
            miah_pkg::OP_SLT:
                sum = ($signed(rs) < $signed(rt)) ? miah_pkg::WORD_ONE : '0;
            miah_pkg::OP_SLTU:  sum = (rs < rt) ? miah_pkg::WORD_ONE : '0;
            miah_pkg::OP_DIV: begin
                wr = 1'b0;
                if (rt == '0) begin
                    // divide by zero: HI keeps the dividend
                    hi_shadow = rs;
                    lo_shadow = rs[31] ? miah_pkg::WORD_ONE : miah_pkg::WORD_ONES;
                end else if (rs == MOST_NEG && rt == miah_pkg::WORD_ONES) begin
                    hi_shadow = '0;
                    lo_shadow = MOST_NEG;
                end else begin
                    // magnitudes, then quotient toward zero, remainder
                    // with the dividend's sign
                    ua = rs[31] ? -rs : rs;
                    ub = rt[31] ? -rt : rt;
                    quo = ua / ub;
                    rem = ua % ub;
                    lo_shadow = (rs[31] != rt[31]) ? -quo : quo;
                    hi_shadow = rs[31] ? -rem : rem;
                end
            end
            miah_pkg::OP_DIVU: begin
                wr = 1'b0;
                if (rt == '0) begin
                    hi_shadow = rs;
                    lo_shadow = miah_pkg::WORD_ONES;
                end else begin
                    hi_shadow = rs % rt;
                    lo_shadow = rs / rt;
                end
            end
            miah_pkg::OP_MULT: begin
                wr = 1'b0;
                prod = {{32{rs[31]}}, rs} * {{32{rt[31]}}, rt};
                hi_shadow = prod[63:32];
                lo_shadow = prod[31:0];
            end
            miah_pkg::OP_MULTU: begin
                wr = 1'b0;
                prod = {32'h0, rs} * {32'h0, rt};
                hi_shadow = prod[63:32];
                lo_shadow = prod[31:0];
            end
            default: wr = 1'b0;
        endcase
        if (ovf)
            wr = 1'b0;
        res_out.result          = wr ? sum : '0;
        res_out.writes_register = wr;
        res_out.overflow        = ovf;
        res_out.hi_value        = hi_shadow;
        res_out.lo_value        = lo_shadow;
        return res_out;
    endfunction

    // transfer monitor: predict on input transfer, compare on output transfer
    always @(posedge i_clk) begin
        miah_pkg::t_out want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                pending_results.push_back(alu_predict(i_in));
                ops_accepted++;
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with no operation outstanding");
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (o_out.result !== want.result) begin
                        $error("result: expected %h, actual %h",
                               want.result, o_out.result);
                        fail_count++;
                    end
                    if (o_out.writes_register !== want.writes_register) begin
                        $error("writes_register: expected %b, actual %b",
                               want.writes_register, o_out.writes_register);
                        fail_count++;
                    end
                    if (o_out.overflow !== want.overflow) begin
                        $error("overflow: expected %b, actual %b",
                               want.overflow, o_out.overflow);
                        fail_count++;
                    end
                    if (o_out.hi_value !== want.hi_value) begin
                        $error("hi_value: expected %h, actual %h",
                               want.hi_value, o_out.hi_value);
                        fail_count++;
                    end
                    if (o_out.lo_value !== want.lo_value) begin
                        $error("lo_value: expected %h, actual %h",
                               want.lo_value, o_out.lo_value);
                        fail_count++;
                    end
                end
            end
        end
    end

    // result side: random stalls, plus a counted hold-off on request
    always @(negedge i_clk) begin
        if (hold_left == 0 && hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic miah_pkg::t_in make_op(
        input logic [miah_pkg::OP_W-1:0]    op,
        input logic [miah_pkg::WORD_W-1:0]  rs,
        input logic [miah_pkg::WORD_W-1:0]  rt,
        input logic [miah_pkg::IMM_W-1:0]   imm,
        input logic [miah_pkg::SHAMT_W-1:0] sh);
        miah_pkg::t_in item;
        item.operation = op;
        item.rs_value  = rs;
        item.rt_value  = rt;
        item.immediate = imm;
        item.shamt     = sh;
        return item;
    endfunction

    // operand mix weighted toward boundary values
    function automatic logic [miah_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0: return '0;
            1: return miah_pkg::WORD_ONE;
            2: return miah_pkg::WORD_ONES;
            3: return MOST_NEG;
            4: return MOST_POS;
            5: return miah_pkg::WORD_W'($urandom_range(15));
            6: return -miah_pkg::WORD_W'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    function automatic miah_pkg::t_in random_op();
        miah_pkg::t_in item;
        if ($urandom_range(19) == 0)
            item.operation = miah_pkg::OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        else
            item.operation = miah_pkg::OP_W'($urandom_range(miah_pkg::OP_MULTU,
                                                             miah_pkg::OP_ADD));
        item.rs_value  = pick_word();
        item.rt_value  = pick_word();
        item.immediate = ($urandom_range(3) == 0) ?
                         miah_pkg::IMM_W'(pick_word()) : miah_pkg::IMM_W'($urandom);
        item.shamt     = miah_pkg::SHAMT_W'($urandom);
        // now and then the most negative dividend over minus one
        if (item.operation == miah_pkg::OP_DIV && $urandom_range(7) == 0) begin
            item.rs_value = MOST_NEG;
            item.rt_value = miah_pkg::WORD_ONES;
        end
        return item;
    endfunction

    // offer one operation; entered and left at a falling edge
    task automatic send_op(input miah_pkg::t_in item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // every logic, add, shift and compare operation, overflow cases, shift extremes, compare signedness
    task automatic test_alu_ops();
        send_op(make_op(miah_pkg::OP_ADD, MOST_POS, miah_pkg::WORD_ONE, 16'h0000, 5'd0));
        send_op(make_op(miah_pkg::OP_ADD, MOST_NEG, MOST_NEG, 16'hFFFF, 5'd31));
        send_op(make_op(miah_pkg::OP_ADDU, MOST_POS, miah_pkg::WORD_ONE, 16'h0000, 5'd0));
        send_op(make_op(miah_pkg::OP_ADDI, MOST_POS, '0, 16'h0001, 5'd0));
        send_op(make_op(miah_pkg::OP_ADDI, MOST_NEG, '0, 16'hFFFF, 5'd0));
        send_op(make_op(miah_pkg::OP_ADDIU, '0, miah_pkg::WORD_ONES, 16'h8000, 5'd0));
        send_op(make_op(miah_pkg::OP_SUBU, '0, miah_pkg::WORD_ONE, 16'h0000, 5'd0));
        send_op(make_op(miah_pkg::OP_OR, 32'h0F0F_0000, 32'h0000_F0F0, 16'h0000, 5'd0));
        send_op(make_op(miah_pkg::OP_ORI, '0, '0, 16'hFFFF, 5'd0));
        send_op(make_op(miah_pkg::OP_XOR, miah_pkg::WORD_ONES, 32'h1234_5678,
                        16'h0000, 5'd0));
        send_op(make_op(miah_pkg::OP_XORI, miah_pkg::WORD_ONES, '0, 16'hFFFF, 5'd0));
        send_op(make_op(miah_pkg::OP_NOR, '0, '0, 16'h0000, 5'd0));
        send_op(make_op(miah_pkg::OP_AND, miah_pkg::WORD_ONES, 32'hA5A5_5A5A,
                        16'h0000, 5'd0));
        send_op(make_op(miah_pkg::OP_ANDI, miah_pkg::WORD_ONES, '0, 16'hFFFF, 5'd0));
        send_op(make_op(miah_pkg::OP_SLL, '0, miah_pkg::WORD_ONE, 16'h0000, 5'd31));
        // variable shifts only look at the low five bits of rs
        send_op(make_op(miah_pkg::OP_SLLV, 32'hFFFF_FFE1, miah_pkg::WORD_ONES,
                        16'h0000, 5'd0));
        send_op(make_op(miah_pkg::OP_SRL, '0, MOST_NEG, 16'h0000, 5'd31));
        send_op(make_op(miah_pkg::OP_SRLV, 32'h0000_003F, miah_pkg::WORD_ONES,
                        16'h0000, 5'd0));
        send_op(make_op(miah_pkg::OP_SRA, '0, MOST_NEG, 16'h0000, 5'd31));
        send_op(make_op(miah_pkg::OP_SRAV, 32'h0000_0024, MOST_POS, 16'h0000, 5'd31));
        send_op(make_op(miah_pkg::OP_SLTI, miah_pkg::WORD_ONES, '0, 16'h0000, 5'd0));
        // sign-extended immediate compared unsigned
        send_op(make_op(miah_pkg::OP_SLTIU, MOST_POS, '0, 16'h8000, 5'd0));
        send_op(make_op(miah_pkg::OP_SLT, MOST_NEG, MOST_POS, 16'h0000, 5'd0));
        send_op(make_op(miah_pkg::OP_SLTU, MOST_NEG, MOST_POS, 16'h0000, 5'd0));
    endtask

    // divide by zero, most negative over minus one, remainder sign, products
    task automatic test_hilo_ops();
        send_op(make_op(miah_pkg::OP_DIV, 32'h0000_0005, '0, 16'h0000, 5'd0));
        send_op(make_op(miah_pkg::OP_DIV, 32'h8000_0005, '0, 16'h0000, 5'd0));
        send_op(make_op(miah_pkg::OP_DIV, MOST_NEG, miah_pkg::WORD_ONES, 16'h0000, 5'd0));
        send_op(make_op(miah_pkg::OP_DIV, 32'hFFFF_FFF9, 32'h0000_0002, 16'h0000, 5'd0));
        send_op(make_op(miah_pkg::OP_DIVU, 32'h0000_0009, '0, 16'h0000, 5'd0));
        send_op(make_op(miah_pkg::OP_DIVU, miah_pkg::WORD_ONES, 32'h0000_0007,
                        16'h0000, 5'd0));
        send_op(make_op(miah_pkg::OP_MULT, miah_pkg::WORD_ONES, 32'h0000_0002,
                        16'h0000, 5'd0));
        send_op(make_op(miah_pkg::OP_MULTU, miah_pkg::WORD_ONES, miah_pkg::WORD_ONES,
                        16'h0000, 5'd0));
        // unused codes leave HI/LO alone and write nothing
        send_op(make_op(OP_UNUSED_LO, miah_pkg::WORD_ONES, miah_pkg::WORD_ONES,
                        16'hFFFF, 5'd31));
        send_op(make_op(OP_UNUSED_HI, miah_pkg::WORD_ONES, miah_pkg::WORD_ONES,
                        16'hFFFF, 5'd31));
    endtask

    task automatic test_random_mix(input int idle_pct, input int stall_pct,
                                   input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_op(random_op());
    endtask

    // long output hold-off while operations keep coming
    task automatic test_output_backpressure();
        miah_pkg::t_in item;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = HOLD_OFF_CYCLES;
        repeat (60) begin
            item = random_op();
            // mostly logic, add, shift and compare ops so the block fills quickly
            if ($urandom_range(3) != 0)
                item.operation = miah_pkg::OP_W'($urandom_range(miah_pkg::OP_SLTU,
                                                                 miah_pkg::OP_ADD));
            send_op(item);
        end
    endtask

    // main sequence
    initial begin
        int drain;
        i_rst_n = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_alu_ops();
        test_hilo_ops();
        test_random_mix(0, 0, 180);
        test_random_mix(83, 0, 150);
        test_random_mix(0, 83, 150);
        test_random_mix(13, 13, 160);
        test_output_backpressure();
        i_in_valid <= 1'b0;

        // wait out all outstanding results, then watch for strays
        while (pending_results.size() != 0)
            @(posedge i_clk);
        for (drain = 0; drain < DRAIN_CYCLES; drain++)
            @(posedge i_clk);

        $display("covered all opcodes incl. unused, %0d operations accepted", ops_accepted);
        $display("%0d results checked under idle, stall and hold-off mixes, %0d mismatches",
                 results_checked, fail_count);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/miah_pkg.sv
hdl/miah_ctrl.sv
hdl/miah_dp.sv
hdl/mips_integer_alu_hilo_unit.sv
bench/tb_top.sv
